// ===== rtl/core/nvms_pkg.sv =====
// Shared types and constants for the nearest video mode select block.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package nvms_pkg;

  localparam int DimW           = 12;
  localparam int ProdW          = 2 * DimW;
  localparam int RateW          = 8;
  localparam int OpW            = 2;
  localparam int IdxW           = 4;
  localparam int StatusW        = 2;
  localparam int ModeIdxW       = 4;
  localparam int RateIdxW       = 2;
  localparam int ModeCountW     = 5;
  localparam int RateCountW     = 3;
  localparam int ApbAddrW       = 3;
  localparam int ApbDataW       = 32;
  localparam int ModeEntriesDef = 16;
  localparam int RateEntriesDef = 4;

  typedef enum logic [OpW-1:0] {
    OpWrMode = 2'd0,
    OpWrRate = 2'd1,
    OpQuery  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StEmpty  = 2'd1,
    StNoMode = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    RegModeCount = 1'b0,
    RegRateCount = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    SIdle,
    SFitSqw,
    SFitSqh,
    SFitCmp,
    SAreaMul,
    SAreaCmp,
    SRateCmp,
    SDone
  } state_e;

endpackage

// ===== rtl/core/nvms_query_if.sv =====
// Input channel of the nearest video mode select block: table writes and queries.
// Depends on nvms_pkg for field widths.
`timescale 1ns / 1ps

interface nvms_query_if;
  logic                         valid;
  logic                         ready;
  logic [nvms_pkg::OpW-1:0]     operation;
  logic [nvms_pkg::IdxW-1:0]    entry_index;
  logic [nvms_pkg::DimW-1:0]    width;
  logic [nvms_pkg::DimW-1:0]    height;
  logic [nvms_pkg::RateW-1:0]   rate;

  modport source (output valid, operation, entry_index, width, height, rate, input ready);
  modport sink   (input valid, operation, entry_index, width, height, rate, output ready);
endinterface

// ===== rtl/core/nvms_result_if.sv =====
// Output channel of the nearest video mode select block: one item per query.
// Depends on nvms_pkg for field widths.
`timescale 1ns / 1ps

interface nvms_result_if;
  logic                            valid;
  logic                            ready;
  logic [nvms_pkg::StatusW-1:0]    status;
  logic [nvms_pkg::ModeIdxW-1:0]   mode_index;
  logic [nvms_pkg::RateIdxW-1:0]   rate_index;
  logic                            mode_changed;
  logic                            rate_changed;

  modport source (output valid, status, mode_index, rate_index, mode_changed, rate_changed,
                  input ready);
  modport sink   (input valid, status, mode_index, rate_index, mode_changed, rate_changed,
                  output ready);
endinterface

// ===== rtl/core/nvms_table_mem.sv =====
// Single write port, single registered read port table memory.
// Depends on nvms_pkg for default sizes.
`timescale 1ns / 1ps

module nvms_table_mem #(
  parameter int  Depth = nvms_pkg::ModeEntriesDef,
  parameter int  DataW = nvms_pkg::ProdW,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/nvms_mul_unit.sv =====
// Shared registered multiplier used for squared distances and mode areas.
// Depends on nvms_pkg for operand widths.
`timescale 1ns / 1ps

module nvms_mul_unit (
  input  logic                        clk_i,
  input  logic [nvms_pkg::DimW-1:0]   a_i,
  input  logic [nvms_pkg::DimW-1:0]   b_i,
  output logic [nvms_pkg::ProdW-1:0]  prod_o
);

  logic [nvms_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= nvms_pkg::ProdW'(a_i) * nvms_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/nearest_video_mode_select_core.sv =====
// Nearest video mode select: top level with sequencer, configuration registers and output register.
// Depends on nvms_pkg, nvms_query_if, nvms_result_if, nvms_table_mem and nvms_mul_unit.
// Writes are taken in SIdle and leave it idle. One shared multiplier and the table read port set a
// query's steps (nm, nr the clamped counts): SFitSqw, SFitSqh and SFitCmp per mode, then SAreaMul and
// SAreaCmp per mode for the largest-area fallback, then SRateCmp per rate unless no mode is usable;
// an empty table goes straight to SDone. No new item is taken while a query runs or its result waits.
// Reset clears both counts, the sequencer and the output valid.
`timescale 1ns / 1ps

module nearest_video_mode_select_core #(
  parameter int MODE_ENTRIES = nvms_pkg::ModeEntriesDef,
  parameter int RATE_ENTRIES = nvms_pkg::RateEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nvms_query_if.sink                      query_i,
  nvms_result_if.source                   result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nvms_pkg::ApbAddrW-1:0]   paddr,
  input  logic [nvms_pkg::ApbDataW-1:0]   pwdata,
  output logic [nvms_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int DimW  = nvms_pkg::DimW;
  localparam int ProdW = nvms_pkg::ProdW;
  localparam int RateW = nvms_pkg::RateW;
  localparam int MAW   = (MODE_ENTRIES > 1) ? $clog2(MODE_ENTRIES) : 1;
  localparam int MCW   = $clog2(MODE_ENTRIES + 1);
  localparam int RAW   = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
  localparam int RCW   = $clog2(RATE_ENTRIES + 1);

  // Configuration registers.
  logic [nvms_pkg::ModeCountW-1:0] mode_count_q;
  logic [nvms_pkg::RateCountW-1:0] rate_count_q;
  logic                            cfg_we;
  nvms_pkg::reg_e                  cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_reg = nvms_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= '0;
      rate_count_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        nvms_pkg::RegModeCount: mode_count_q <= pwdata[nvms_pkg::ModeCountW-1:0];
        nvms_pkg::RegRateCount: rate_count_q <= pwdata[nvms_pkg::RateCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      nvms_pkg::RegModeCount: prdata = nvms_pkg::ApbDataW'(mode_count_q);
      nvms_pkg::RegRateCount: prdata = nvms_pkg::ApbDataW'(rate_count_q);
      default:                prdata = '0;
    endcase
  end

  // Counts clamped to the table sizes.
  logic [31:0]    mode_count_ext, rate_count_ext, nm_full, nr_full;
  logic [MCW-1:0] nm;
  logic [RCW-1:0] nr;

  assign mode_count_ext = 32'(mode_count_q);
  assign rate_count_ext = 32'(rate_count_q);
  assign nm_full = (mode_count_ext > 32'(MODE_ENTRIES)) ? 32'(MODE_ENTRIES) : mode_count_ext;
  assign nr_full = (rate_count_ext > 32'(RATE_ENTRIES)) ? 32'(RATE_ENTRIES) : rate_count_ext;
  assign nm = nm_full[MCW-1:0];
  assign nr = nr_full[RCW-1:0];

  // Sequencer and datapath registers.
  nvms_pkg::state_e state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [DimW-1:0]        req_w_q, req_w_d, req_h_q, req_h_d;
  logic [RateW-1:0]       req_r_q, req_r_d;
  logic [MCW-1:0]         idx_q, idx_d;
  logic [RCW-1:0]         ridx_q, ridx_d;
  logic                   fit_q, fit_d;
  logic [ProdW-1:0]       acc_q, acc_d;
  logic [ProdW:0]         best_score_q, best_score_d;
  logic                   found_q, found_d;
  logic [ProdW-1:0]       largest_q, largest_d;
  logic [MAW-1:0]         best_idx_q, best_idx_d;
  logic [DimW-1:0]        best_w_q, best_w_d, best_h_q, best_h_d;
  logic                   rfound_q, rfound_d;
  logic [RateW-1:0]       rdiff_q, rdiff_d;
  logic [RAW-1:0]         rbest_q, rbest_d;
  logic [RateW-1:0]       best_rate_q, best_rate_d;
  logic [nvms_pkg::StatusW-1:0] status_q, status_d;

  logic [nvms_pkg::StatusW-1:0]  out_status_q;
  logic [nvms_pkg::ModeIdxW-1:0] out_mode_idx_q;
  logic [nvms_pkg::RateIdxW-1:0] out_rate_idx_q;
  logic                          out_mode_chg_q, out_rate_chg_q;

  // Table memories and the shared multiplier.
  logic                   mode_we, rate_we;
  logic [31:0]            wix;
  logic [2*DimW-1:0]      mode_rd;
  logic [RateW-1:0]       rate_rd;
  logic [DimW-1:0]        mul_a, mul_b;
  logic [ProdW-1:0]       prod;

  assign wix = 32'(query_i.entry_index);

  nvms_table_mem #(
    .Depth (MODE_ENTRIES),
    .DataW (2 * DimW)
  ) u_mode_mem (
    .clk_i   (clk_i),
    .we_i    (mode_we),
    .waddr_i (wix[MAW-1:0]),
    .wdata_i ({query_i.width, query_i.height}),
    .raddr_i (idx_d[MAW-1:0]),
    .rdata_o (mode_rd)
  );

  nvms_table_mem #(
    .Depth (RATE_ENTRIES),
    .DataW (RateW)
  ) u_rate_mem (
    .clk_i   (clk_i),
    .we_i    (rate_we),
    .waddr_i (wix[RAW-1:0]),
    .wdata_i (query_i.rate),
    .raddr_i (ridx_d[RAW-1:0]),
    .rdata_o (rate_rd)
  );

  nvms_mul_unit u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Per-entry arithmetic.
  logic [DimW-1:0]  ent_w, ent_h, dw, dh;
  logic             fits, last, rlast, rate_ok;
  logic [ProdW:0]   score;
  logic [MCW-1:0]   idx_next;
  logic [RCW-1:0]   ridx_next;
  logic [RateW-1:0] rd;
  logic             query_ready, out_load;

  assign ent_w     = mode_rd[2*DimW-1:DimW];
  assign ent_h     = mode_rd[DimW-1:0];
  assign fits      = (ent_w >= req_w_q) && (ent_h >= req_h_q);
  assign dw        = ent_w - req_w_q;
  assign dh        = ent_h - req_h_q;
  assign score     = {1'b0, acc_q} + {1'b0, prod};
  assign idx_next  = idx_q + MCW'(1);
  assign ridx_next = ridx_q + RCW'(1);
  assign last      = (idx_next == nm);
  assign rlast     = (ridx_next == nr);
  assign rate_ok   = (rate_rd <= req_r_q);
  assign rd        = req_r_q - rate_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nvms_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    req_w_d      = req_w_q;
    req_h_d      = req_h_q;
    req_r_d      = req_r_q;
    idx_d        = idx_q;
    ridx_d       = ridx_q;
    fit_d        = fit_q;
    acc_d        = acc_q;
    best_score_d = best_score_q;
    found_d      = found_q;
    largest_d    = largest_q;
    best_idx_d   = best_idx_q;
    best_w_d     = best_w_q;
    best_h_d     = best_h_q;
    rfound_d     = rfound_q;
    rdiff_d      = rdiff_q;
    rbest_d      = rbest_q;
    best_rate_d  = best_rate_q;
    status_d     = status_q;
    mode_we      = 1'b0;
    rate_we      = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    query_ready  = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      nvms_pkg::SIdle: begin
        query_ready = 1'b1;
        if (query_i.valid) begin
          unique case (nvms_pkg::op_e'(query_i.operation))
            nvms_pkg::OpWrMode: mode_we = (wix < 32'(MODE_ENTRIES));
            nvms_pkg::OpWrRate: rate_we = (wix < 32'(RATE_ENTRIES));
            nvms_pkg::OpQuery: begin
              req_w_d   = query_i.width;
              req_h_d   = query_i.height;
              req_r_d   = query_i.rate;
              idx_d     = '0;
              ridx_d    = '0;
              found_d   = 1'b0;
              largest_d = '0;
              rfound_d  = 1'b0;
              if ((nm == '0) || (nr == '0)) begin
                status_d = nvms_pkg::StEmpty;
                state_d  = nvms_pkg::SDone;
              end else begin
                state_d = nvms_pkg::SFitSqw;
              end
            end
            default: ;
          endcase
        end
      end
      nvms_pkg::SFitSqw: begin
        mul_a   = dw;
        mul_b   = dw;
        fit_d   = fits;
        state_d = nvms_pkg::SFitSqh;
      end
      nvms_pkg::SFitSqh: begin
        mul_a   = dh;
        mul_b   = dh;
        acc_d   = prod;
        state_d = nvms_pkg::SFitCmp;
      end
      nvms_pkg::SFitCmp: begin
        if (fit_q && (!found_q || (score < best_score_q))) begin
          found_d      = 1'b1;
          best_score_d = score;
          best_idx_d   = idx_q[MAW-1:0];
          best_w_d     = ent_w;
          best_h_d     = ent_h;
        end
        if (last) begin
          if (found_d) begin
            state_d = nvms_pkg::SRateCmp;
          end else begin
            idx_d   = '0;
            state_d = nvms_pkg::SAreaMul;
          end
        end else begin
          idx_d   = idx_next;
          state_d = nvms_pkg::SFitSqw;
        end
      end
      nvms_pkg::SAreaMul: begin
        mul_a   = ent_w;
        mul_b   = ent_h;
        state_d = nvms_pkg::SAreaCmp;
      end
      nvms_pkg::SAreaCmp: begin
        if (prod > largest_q) begin
          largest_d  = prod;
          found_d    = 1'b1;
          best_idx_d = idx_q[MAW-1:0];
          best_w_d   = ent_w;
          best_h_d   = ent_h;
        end
        if (last) begin
          if (found_d) begin
            state_d = nvms_pkg::SRateCmp;
          end else begin
            status_d = nvms_pkg::StNoMode;
            state_d  = nvms_pkg::SDone;
          end
        end else begin
          idx_d   = idx_next;
          state_d = nvms_pkg::SAreaMul;
        end
      end
      nvms_pkg::SRateCmp: begin
        // Entry 0 is the fallback when no rate lies at or below the request.
        if (ridx_q == '0) begin
          rbest_d     = '0;
          best_rate_d = rate_rd;
        end
        if (rate_ok && (!rfound_q || (rd < rdiff_q))) begin
          rfound_d    = 1'b1;
          rdiff_d     = rd;
          rbest_d     = ridx_q[RAW-1:0];
          best_rate_d = rate_rd;
        end
        if (rlast) begin
          status_d = nvms_pkg::StOk;
          state_d  = nvms_pkg::SDone;
        end else begin
          ridx_d = ridx_next;
        end
      end
      nvms_pkg::SDone: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = nvms_pkg::SIdle;
        end
      end
      default: state_d = nvms_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    req_w_q      <= req_w_d;
    req_h_q      <= req_h_d;
    req_r_q      <= req_r_d;
    idx_q        <= idx_d;
    ridx_q       <= ridx_d;
    fit_q        <= fit_d;
    acc_q        <= acc_d;
    best_score_q <= best_score_d;
    found_q      <= found_d;
    largest_q    <= largest_d;
    best_idx_q   <= best_idx_d;
    best_w_q     <= best_w_d;
    best_h_q     <= best_h_d;
    rfound_q     <= rfound_d;
    rdiff_q      <= rdiff_d;
    rbest_q      <= rbest_d;
    best_rate_q  <= best_rate_d;
    status_q     <= status_d;
  end

  // Output register.
  logic        res_ok;
  logic [31:0] best_idx_ext, rbest_ext;

  assign res_ok       = (status_q == nvms_pkg::StOk);
  assign best_idx_ext = 32'(best_idx_q);
  assign rbest_ext    = 32'(rbest_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q   <= status_q;
      out_mode_idx_q <= res_ok ? best_idx_ext[nvms_pkg::ModeIdxW-1:0] : '0;
      out_rate_idx_q <= res_ok ? rbest_ext[nvms_pkg::RateIdxW-1:0] : '0;
      out_mode_chg_q <= res_ok && ((best_w_q != req_w_q) || (best_h_q != req_h_q));
      out_rate_chg_q <= res_ok && (best_rate_q != req_r_q);
    end
  end

  assign query_i.ready         = query_ready;
  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_status_q;
  assign result_o.mode_index   = out_mode_idx_q;
  assign result_o.rate_index   = out_rate_idx_q;
  assign result_o.mode_changed = out_mode_chg_q;
  assign result_o.rate_changed = out_rate_chg_q;

  // Assertions.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == nvms_pkg::SDone))
    else $error("Result item appeared without the sequencer finishing a query.");

  a_failed_query_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != nvms_pkg::StOk)) |->
      ((out_mode_idx_q == '0) && (out_rate_idx_q == '0) && !out_mode_chg_q && !out_rate_chg_q))
    else $error("Failed query item carries nonzero result fields.");

  a_mode_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == nvms_pkg::SFitCmp) || (state_q == nvms_pkg::SAreaCmp)) |-> (idx_q < nm))
    else $error("Mode scan index ran past the mode count.");

  a_rate_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nvms_pkg::SRateCmp) |-> (ridx_q < nr))
    else $error("Rate scan index ran past the rate count.");

endmodule

// ===== tb/sv/tb_nearest_video_mode_select_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_video_mode_select_core: a directed table of writes,
// queries and register settings, then random phases, each result checked against a stated pick or a predictor.
// Depends on nvms_pkg, nvms_query_if, nvms_result_if and the block's RTL.

module tb_nearest_video_mode_select_core;

  localparam int DimW           = nvms_pkg::DimW;
  localparam int RateW          = nvms_pkg::RateW;
  localparam int OpW            = nvms_pkg::OpW;
  localparam int IdxW           = nvms_pkg::IdxW;
  localparam int ModeIdxW       = nvms_pkg::ModeIdxW;
  localparam int RateIdxW       = nvms_pkg::RateIdxW;
  localparam int ModeCountW     = nvms_pkg::ModeCountW;
  localparam int RateCountW     = nvms_pkg::RateCountW;
  localparam int ApbAddrW       = nvms_pkg::ApbAddrW;
  localparam int ApbDataW       = nvms_pkg::ApbDataW;
  localparam int ModeEntriesDef = nvms_pkg::ModeEntriesDef;
  localparam int RateEntriesDef = nvms_pkg::RateEntriesDef;

  localparam int unsigned ClkHalf       = 5;
  localparam logic [OpW-1:0] OpIgnored  = 2'd3;
  localparam int unsigned RandItems     = 1400;
  localparam int unsigned PhaseLen      = 100;
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldAt        = 200;
  localparam int unsigned HoldCycles    = 800;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned NoRateDiff    = 32'hFFFF;
  localparam int unsigned RateDiffInit  = 32'h10000;

  typedef struct packed {
    nvms_pkg::status_e     status;
    logic [ModeIdxW-1:0]   mode_index;
    logic [RateIdxW-1:0]   rate_index;
    logic                  mode_changed;
    logic                  rate_changed;
  } pick_t;

  typedef struct {
    bit                    is_cfg;
    logic [ModeCountW-1:0] mode_cnt;
    logic [RateCountW-1:0] rate_cnt;
    logic [OpW-1:0]        op;
    logic [IdxW-1:0]       idx;
    logic [DimW-1:0]       w;
    logic [DimW-1:0]       h;
    logic [RateW-1:0]      r;
    bit                    has_known;
    pick_t                 known;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  nvms_query_if  qi ();
  nvms_result_if ro ();

  nearest_video_mode_select_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .query_i  (qi),
    .result_o (ro),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [DimW-1:0]       mode_w_mirror [ModeEntriesDef];
  logic [DimW-1:0]       mode_h_mirror [ModeEntriesDef];
  logic [RateW-1:0]      rate_mirror   [RateEntriesDef];
  bit                    mode_written  [ModeEntriesDef];
  bit                    rate_written  [RateEntriesDef];
  logic [ModeCountW-1:0] mode_count_cfg;
  logic [RateCountW-1:0] rate_count_cfg;
  pick_t                 pending_picks [$];
  dir_row_t              dir_rows [$];
  int unsigned           fail_count;
  int unsigned           results_seen;
  int unsigned           rand_items;
  bit                    no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  function automatic pick_t nearest_mode_lookup(logic [DimW-1:0] rw, logic [DimW-1:0] rh,
                                                logic [RateW-1:0] rr);
    int unsigned nm, nr, i, best, rbest, dw, dh, score, best_score, area, largest, d, rdiff;
    bit          found;
    pick_t       res;
    res        = '0;
    res.status = nvms_pkg::StOk;
    nm = (mode_count_cfg > ModeEntriesDef) ? ModeEntriesDef : mode_count_cfg;
    nr = (rate_count_cfg > RateEntriesDef) ? RateEntriesDef : rate_count_cfg;
    if (nm == 0 || nr == 0) begin
      res.status = nvms_pkg::StEmpty;
      return res;
    end
    found      = 1'b0;
    best       = 0;
    best_score = 0;
    for (i = 0; i < nm; i++) begin
      if (mode_w_mirror[i] >= rw && mode_h_mirror[i] >= rh) begin
        dw    = mode_w_mirror[i] - rw;
        dh    = mode_h_mirror[i] - rh;
        score = dw * dw + dh * dh;
        if (!found || score < best_score) begin
          found      = 1'b1;
          best       = i;
          best_score = score;
        end
      end
    end
    // Nothing covers the request: fall back to the first entry of largest area.
    if (!found) begin
      largest = 0;
      for (i = 0; i < nm; i++) begin
        area = mode_w_mirror[i] * mode_h_mirror[i];
        if (area > largest) begin
          largest = area;
          best    = i;
          found   = 1'b1;
        end
      end
    end
    if (!found) begin
      res.status = nvms_pkg::StNoMode;
      return res;
    end
    rbest = 0;
    rdiff = RateDiffInit;
    for (i = 0; i < nr; i++) begin
      d = (rr >= rate_mirror[i]) ? rr - rate_mirror[i] : NoRateDiff;
      if (d < NoRateDiff && d < rdiff) begin
        rdiff = d;
        rbest = i;
      end
    end
    res.mode_index   = ModeIdxW'(best);
    res.rate_index   = RateIdxW'(rbest);
    res.mode_changed = (mode_w_mirror[best] != rw) || (mode_h_mirror[best] != rh);
    res.rate_changed = (rate_mirror[rbest] != rr);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DimW-1:0] rand_dim();
    case ($urandom_range(0, 4))
      0:       return DimW'($urandom_range(0, 15));
      1:       return DimW'($urandom_range(4080, 4095));
      default: return DimW'($urandom);
    endcase
  endfunction

  function automatic logic [RateW-1:0] rand_rate();
    case ($urandom_range(0, 4))
      0:       return RateW'($urandom_range(0, 3));
      1:       return RateW'($urandom_range(252, 255));
      default: return RateW'($urandom);
    endcase
  endfunction

  function automatic dir_row_t blank_row();
    dir_row_t row;
    row.is_cfg    = 1'b0;
    row.mode_cnt  = '0;
    row.rate_cnt  = '0;
    row.op        = nvms_pkg::OpQuery;
    row.idx       = '0;
    row.w         = '0;
    row.h         = '0;
    row.r         = '0;
    row.has_known = 1'b0;
    row.known     = '0;
    return row;
  endfunction

  function automatic void add_cfg(logic [ModeCountW-1:0] m, logic [RateCountW-1:0] r);
    dir_row_t row;
    row          = blank_row();
    row.is_cfg   = 1'b1;
    row.mode_cnt = m;
    row.rate_cnt = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(logic [OpW-1:0] op, logic [IdxW-1:0] idx,
                                   logic [DimW-1:0] w, logic [DimW-1:0] h,
                                   logic [RateW-1:0] r);
    dir_row_t row;
    row     = blank_row();
    row.op  = op;
    row.idx = idx;
    row.w   = w;
    row.h   = h;
    row.r   = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(logic [DimW-1:0] w, logic [DimW-1:0] h,
                                    logic [RateW-1:0] r, nvms_pkg::status_e st,
                                    logic [ModeIdxW-1:0] mi, logic [RateIdxW-1:0] ri,
                                    logic mc, logic rc);
    dir_row_t row;
    row                    = blank_row();
    row.w                  = w;
    row.h                  = h;
    row.r                  = r;
    row.has_known          = 1'b1;
    row.known.status       = st;
    row.known.mode_index   = mi;
    row.known.rate_index   = ri;
    row.known.mode_changed = mc;
    row.known.rate_changed = rc;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(logic [OpW-1:0] op, logic [IdxW-1:0] idx, logic [DimW-1:0] w,
                           logic [DimW-1:0] h, logic [RateW-1:0] r, bit has_known,
                           pick_t known);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      qi.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    qi.valid       <= 1'b1;
    qi.operation   <= op;
    qi.entry_index <= idx;
    qi.width       <= w;
    qi.height      <= h;
    qi.rate        <= r;
    @(posedge clk_i);
    while (!qi.ready) @(posedge clk_i);
    case (op)
      nvms_pkg::OpWrMode: begin
        if (idx < ModeEntriesDef) begin
          mode_w_mirror[idx] = w;
          mode_h_mirror[idx] = h;
          mode_written[idx]  = 1'b1;
        end
      end
      nvms_pkg::OpWrRate: begin
        if (idx < RateEntriesDef) begin
          rate_mirror[idx]  = r;
          rate_written[idx] = 1'b1;
        end
      end
      nvms_pkg::OpQuery: begin
        pending_picks.push_back(has_known ? known : nearest_mode_lookup(w, h, r));
      end
      default: ;
    endcase
  endtask

  task automatic apb_write(nvms_pkg::reg_e ridx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle, after all queries have answered.
  task automatic program_counts(logic [ModeCountW-1:0] m, logic [RateCountW-1:0] r);
    qi.valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    apb_write(nvms_pkg::RegModeCount, ApbDataW'(m));
    apb_write(nvms_pkg::RegRateCount, ApbDataW'(r));
    mode_count_cfg = m;
    rate_count_cfg = r;
  endtask

  task automatic run_phase(logic [ModeCountW-1:0] m, logic [RateCountW-1:0] r);
    int unsigned      nm, nr, j, roll, shape;
    logic [DimW-1:0]  w, h;
    logic [RateW-1:0] rt;
    logic [IdxW-1:0]  idx;
    program_counts(m, r);
    no_gaps = ($urandom_range(0, 3) == 0);
    nm = (m > ModeEntriesDef) ? ModeEntriesDef : m;
    nr = (r > RateEntriesDef) ? RateEntriesDef : r;
    // Every entry a query can reach is written before the first query of the phase.
    for (j = 0; j < nm; j++) begin
      if (!mode_written[j]) begin
        send_item(nvms_pkg::OpWrMode, IdxW'(j), rand_dim(), rand_dim(), rand_rate(), 1'b0,
                  '0);
        rand_items++;
      end
    end
    for (j = 0; j < nr; j++) begin
      if (!rate_written[j]) begin
        send_item(nvms_pkg::OpWrRate, IdxW'(j), rand_dim(), rand_dim(), rand_rate(), 1'b0,
                  '0);
        rand_items++;
      end
    end
    repeat (PhaseLen) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        shape = $urandom_range(0, 9);
        if (shape < 4 && nm != 0) begin
          j = $urandom_range(0, nm - 1);
          w = mode_w_mirror[j];
          h = mode_h_mirror[j];
          if (shape >= 2) begin
            if (w > 3) w = w - DimW'($urandom_range(0, 3));
            if (h > 3) h = h - DimW'($urandom_range(0, 3));
          end
        end else if (shape == 8) begin
          w = '1;
          h = '1;
        end else if (shape == 9) begin
          w = '0;
          h = '0;
        end else begin
          w = rand_dim();
          h = rand_dim();
        end
        if ($urandom_range(0, 1) == 1 && nr != 0) begin
          rt = rate_mirror[$urandom_range(0, nr - 1)] + RateW'($urandom_range(0, 2));
        end else begin
          rt = rand_rate();
        end
        send_item(nvms_pkg::OpQuery, IdxW'($urandom), w, h, rt, 1'b0, '0);
        rand_items++;
      end else if (roll < 75) begin
        send_item(nvms_pkg::OpWrMode, IdxW'($urandom), rand_dim(), rand_dim(), rand_rate(),
                  1'b0, '0);
        rand_items++;
      end else if (roll < 92) begin
        idx = IdxW'($urandom_range(0, 15));
        if ($urandom_range(0, 2) != 0) idx = IdxW'($urandom_range(0, RateEntriesDef - 1));
        send_item(nvms_pkg::OpWrRate, idx, rand_dim(), rand_dim(), rand_rate(), 1'b0, '0);
        rand_items++;
      end else begin
        send_item(OpIgnored, IdxW'($urandom), rand_dim(), rand_dim(), rand_rate(), 1'b0, '0);
        rand_items++;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    bit          hold_done;
    pick_t       want;
    stall     = 0;
    hold_done = 1'b0;
    ro.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (ro.valid && ro.ready) begin
        results_seen++;
        if (pending_picks.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("unexpected result item: status=%0d mode=%0d rate=%0d mc=%0b rc=%0b",
                     ro.status, ro.mode_index, ro.rate_index, ro.mode_changed,
                     ro.rate_changed);
          end
        end else begin
          want = pending_picks.pop_front();
          if ({ro.status, ro.mode_index, ro.rate_index, ro.mode_changed, ro.rate_changed}
              !== want) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("mismatch: expected status=%0d mode=%0d rate=%0d mc=%0b rc=%0b, %s",
                       want.status, want.mode_index, want.rate_index, want.mode_changed,
                       want.rate_changed, "got:");
              $display("          actual   status=%0d mode=%0d rate=%0d mc=%0b rc=%0b",
                       ro.status, ro.mode_index, ro.rate_index, ro.mode_changed,
                       ro.rate_changed);
            end
          end
        end
      end
      // One long hold-off lets the block fill up while queries keep arriving.
      if (!hold_done && results_seen >= HoldAt) begin
        hold_done = 1'b1;
        ro.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (stall != 0) begin
        stall--;
        ro.ready <= 1'b0;
      end else begin
        ro.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((qi.valid && qi.ready) || (ro.valid && ro.ready) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : main_seq
    qi.valid       <= 1'b0;
    qi.operation   <= nvms_pkg::OpWrMode;
    qi.entry_index <= '0;
    qi.width       <= '0;
    qi.height      <= '0;
    qi.rate        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_ni         <= 1'b0;
    mode_count_cfg = '0;
    rate_count_cfg = '0;
    fail_count     = 0;
    results_seen   = 0;
    rand_items     = 0;
    no_gaps        = 1'b0;
    foreach (mode_written[i]) mode_written[i] = 1'b0;
    foreach (rate_written[i]) rate_written[i] = 1'b0;

    add_known(12'd640, 12'd480, 8'd60, nvms_pkg::StEmpty, 4'd0, 2'd0, 1'b0, 1'b0);
    add_cfg(5'd3, 3'd0);
    add_item(nvms_pkg::OpWrMode, 4'd0, 12'd640, 12'd480, 8'd0);
    add_item(nvms_pkg::OpWrMode, 4'd1, 12'd4095, 12'd4095, 8'd0);
    add_item(nvms_pkg::OpWrMode, 4'd2, 12'd0, 12'd0, 8'd0);
    add_item(nvms_pkg::OpWrRate, 4'd0, 12'd0, 12'd0, 8'd60);
    add_item(nvms_pkg::OpWrRate, 4'd1, 12'd0, 12'd0, 8'd255);
    add_known(12'd640, 12'd480, 8'd60, nvms_pkg::StEmpty, 4'd0, 2'd0, 1'b0, 1'b0);
    add_cfg(5'd3, 3'd2);
    add_known(12'd640, 12'd480, 8'd60, nvms_pkg::StOk, 4'd0, 2'd0, 1'b0, 1'b0);
    add_known(12'd800, 12'd600, 8'd255, nvms_pkg::StOk, 4'd1, 2'd1, 1'b1, 1'b0);
    add_known(12'd0, 12'd0, 8'd0, nvms_pkg::StOk, 4'd2, 2'd0, 1'b0, 1'b1);
    add_item(nvms_pkg::OpWrRate, 4'd4, 12'd0, 12'd0, 8'd0);
    add_item(nvms_pkg::OpWrRate, 4'd15, 12'd0, 12'd0, 8'd0);
    add_item(OpIgnored, 4'd15, 12'd4095, 12'd4095, 8'd255);
    add_item(nvms_pkg::OpQuery, 4'd0, 12'd0, 12'd0, 8'd0);
    add_item(nvms_pkg::OpWrMode, 4'd1, 12'd4095, 12'd100, 8'd0);
    add_item(nvms_pkg::OpQuery, 4'd0, 12'd4095, 12'd4095, 8'd100);
    add_item(nvms_pkg::OpWrMode, 4'd2, 12'd640, 12'd480, 8'd0);
    add_item(nvms_pkg::OpQuery, 4'd0, 12'd600, 12'd400, 8'd255);
    add_item(nvms_pkg::OpWrMode, 4'd0, 12'd0, 12'd4095, 8'd0);
    add_item(nvms_pkg::OpWrMode, 4'd1, 12'd4095, 12'd0, 8'd0);
    add_item(nvms_pkg::OpWrMode, 4'd2, 12'd0, 12'd0, 8'd0);
    add_known(12'd4095, 12'd4095, 8'd255, nvms_pkg::StNoMode, 4'd0, 2'd0, 1'b0, 1'b0);
    add_item(nvms_pkg::OpQuery, 4'd0, 12'd0, 12'd0, 8'd255);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        program_counts(dir_rows[k].mode_cnt, dir_rows[k].rate_cnt);
      end else begin
        send_item(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].w, dir_rows[k].h,
                  dir_rows[k].r, dir_rows[k].has_known, dir_rows[k].known);
      end
    end

    // Counts beyond the table sizes open and close this list, with the usual extremes between.
    run_phase(5'd31, 3'd7);
    run_phase(5'd16, 3'd4);
    run_phase(5'd1, 3'd1);
    run_phase(5'd0, 3'd4);
    run_phase(5'd16, 3'd0);
    run_phase(5'd17, 3'd5);
    while (rand_items < RandItems) begin
      run_phase(ModeCountW'($urandom_range(0, 31)), RateCountW'($urandom_range(0, 7)));
    end

    qi.valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_picks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
